// ===== design/tep_pkg.sv =====
`timescale 1ns / 1ps

package tep_pkg;

  localparam logic [4:0] EVT_SYNC = 5'd0;
  localparam logic [4:0] EVT_KEY  = 5'd1;
  localparam logic [4:0] EVT_ABS  = 5'd3;

  localparam logic [9:0] CODE_POS_X = 10'h035;
  localparam logic [9:0] CODE_POS_Y = 10'h036;
  localparam logic [9:0] CODE_TOUCH = 10'h14A;
  localparam logic [9:0] CODE_DTAP  = 10'h14D;

  localparam int SCALE_SHIFT = 12;

  localparam logic [1:0] REG_SCALE_ENABLE   = 2'd0;
  localparam logic [1:0] REG_SCREEN_WIDTH   = 2'd1;
  localparam logic [1:0] REG_SCREEN_HEIGHT  = 2'd2;
  localparam logic [1:0] REG_MOVE_THRESHOLD = 2'd3;

  localparam logic [1:0] BTN_NONE  = 2'd0;
  localparam logic [1:0] BTN_LEFT  = 2'd1;
  localparam logic [1:0] BTN_RIGHT = 2'd2;

  typedef struct packed {
    logic        scale_enable;
    logic [11:0] screen_width;
    logic [11:0] screen_height;
    logic [15:0] move_threshold;
  } tep_cfg_t;

  typedef struct packed {
    logic [4:0]  event_type;
    logic [9:0]  event_code;
    logic [31:0] event_value;
  } tep_event_t;

  typedef struct packed {
    logic        emit;
    logic [15:0] pointer_x;
    logic [15:0] pointer_y;
    logic [1:0]  button_state;
  } tep_result_t;

endpackage

// ===== design/touch_event_to_pointer.sv =====
`timescale 1ns / 1ps
// Touch event to pointer converter.
// Slave stream: s_tuser carries the event type, s_tdata the event code and
// value. Master stream: m_tdata carries the held X and Y coordinates and the
// button state. Absolute X/Y moves over move_threshold update the held coordinates
// and give no transfer; touch and double-tap keys always give one; a sync event
// gives a left-button drag transfer when one finger stayed down and the position moved.
// The config channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// scale_enable (0), screen_width (1), screen_height (2), move_threshold (3);
// cfg_ready is always high. Write config only while the block is idle.
// An event is taken into an input register, evaluated from there by one 12x16
// multiply, compare and flag update, and its result lands in the output
// register, from which m_tvalid rises when the event gives a transfer.
// Throughput: one event per cycle while the output register is free (m_tvalid
// low or m_tready high), set by the input-to-output stage.
// When m_tready is low the result holds in the output register; one more event
// waits in the input register, then s_tready drops until the result is taken.
// Reset (rst, synchronous) empties both registers, clears all tracking state
// and loads the register defaults.

module touch_event_to_pointer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // event_code[9:0], event_value[41:10], zero pad
  input  logic [4:0]  s_tuser,   // event_type[4:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // pointer_x[15:0], pointer_y[31:16], button_state[33:32]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import tep_pkg::*;

  tep_cfg_t    cfg;
  tep_event_t  s1_evt;
  logic        s1_valid;
  logic        out_free;
  logic        s1_go;
  tep_result_t res;
  logic [15:0] out_x, out_y;
  logic [1:0]  out_btn;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign s1_go     = s1_valid && out_free;
  assign s_tready  = !s1_valid || out_free;

  tep_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_evt.event_type  <= s_tuser;
      s1_evt.event_code  <= s_tdata[9:0];
      s1_evt.event_value <= s_tdata[41:10];
    end
  end

  tep_event_proc u_proc (
    .clk (clk),
    .rst (rst),
    .go  (s1_go),
    .evt (s1_evt),
    .cfg (cfg),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_go && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res.emit) begin
      out_x   <= res.pointer_x;
      out_y   <= res.pointer_y;
      out_btn <= res.button_state;
    end
  end

  assign m_tdata = {6'd0, out_btn, out_y, out_x};

endmodule

// ===== design/tep_cfg_regs.sv =====
`timescale 1ns / 1ps

module tep_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [15:0]        wr_data,
  output tep_pkg::tep_cfg_t  cfg
);
  import tep_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_enable   <= 1'b0;
      cfg.screen_width   <= 12'd600;
      cfg.screen_height  <= 12'd800;
      cfg.move_threshold <= 16'd0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SCALE_ENABLE:   cfg.scale_enable   <= wr_data[0];
        REG_SCREEN_WIDTH:   cfg.screen_width   <= wr_data[11:0];
        REG_SCREEN_HEIGHT:  cfg.screen_height  <= wr_data[11:0];
        REG_MOVE_THRESHOLD: cfg.move_threshold <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/tep_event_proc.sv =====
`timescale 1ns / 1ps

module tep_event_proc (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  tep_pkg::tep_event_t   evt,
  input  tep_pkg::tep_cfg_t     cfg,
  output tep_pkg::tep_result_t  res
);
  import tep_pkg::*;

  logic [15:0] held_x, held_y, frame_x, frame_y;
  logic        touch_latched, touch_pending, dtap_latched, dtap_pending;

  logic [15:0] sat_pos;
  logic [11:0] dim;
  logic [27:0] product;
  logic [15:0] pos;
  logic [15:0] held_sel;
  logic [15:0] diff;
  logic        move_ok;
  logic        pressed;
  logic        is_x, is_y;

  always_comb begin
    if (evt.event_value[31])          sat_pos = 16'd0;
    else if (|evt.event_value[30:16]) sat_pos = 16'hFFFF;
    else                              sat_pos = evt.event_value[15:0];
  end

  assign is_x     = (evt.event_code == CODE_POS_X);
  assign is_y     = (evt.event_code == CODE_POS_Y);
  assign dim      = is_x ? cfg.screen_width : cfg.screen_height;
  assign product  = 28'(dim) * 28'(sat_pos);
  assign pos      = cfg.scale_enable ? product[SCALE_SHIFT +: 16] : sat_pos;
  assign held_sel = is_x ? held_x : held_y;
  assign diff     = (held_sel > pos) ? (held_sel - pos) : (pos - held_sel);
  assign move_ok  = (diff > cfg.move_threshold);
  assign pressed  = |evt.event_value;

  always_comb begin
    res.emit         = 1'b0;
    res.pointer_x    = held_x;
    res.pointer_y    = held_y;
    res.button_state = BTN_NONE;
    if (evt.event_type == EVT_KEY) begin
      if (evt.event_code == CODE_TOUCH) begin
        res.emit         = 1'b1;
        res.button_state = pressed ? BTN_LEFT : BTN_NONE;
      end else if (evt.event_code == CODE_DTAP) begin
        res.emit         = 1'b1;
        res.button_state = pressed ? BTN_RIGHT : BTN_NONE;
      end
    end else if (evt.event_type == EVT_SYNC) begin
      res.emit = !dtap_latched && !dtap_pending && touch_latched && touch_pending &&
                 ((held_x != frame_x) || (held_y != frame_y));
      res.button_state = BTN_LEFT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_x        <= 16'd0;
      held_y        <= 16'd0;
      frame_x       <= 16'd0;
      frame_y       <= 16'd0;
      touch_latched <= 1'b0;
      touch_pending <= 1'b0;
      dtap_latched  <= 1'b0;
      dtap_pending  <= 1'b0;
    end else if (go) begin
      if (evt.event_type == EVT_ABS) begin
        if (is_x && move_ok) held_x <= pos;
        if (is_y && move_ok) held_y <= pos;
      end else if (evt.event_type == EVT_KEY) begin
        if (evt.event_code == CODE_TOUCH) touch_pending <= pressed;
        if (evt.event_code == CODE_DTAP)  dtap_pending  <= pressed;
      end else if (evt.event_type == EVT_SYNC) begin
        frame_x       <= held_x;
        frame_y       <= held_y;
        touch_latched <= touch_pending;
        dtap_latched  <= dtap_pending;
      end
    end
  end

endmodule

// ===== design/tep_checker.sv =====
`timescale 1ns / 1ps

module tep_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        cfg_ready
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output transfer changed");

  a_button: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[33:32] != 2'd3) && (m_tdata[39:34] == 6'd0))
    else $error("bad button code or padding");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without input transfer two cycles earlier");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config channel not ready");

endmodule

bind touch_event_to_pointer tep_checker u_tep_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_ready (cfg_ready)
);
